// File: hw/rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants, codes and port structs of the sparse polynomial block.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

  localparam int MAX_DEGREE = 15;
  localparam int NDEG       = MAX_DEGREE + 1;
  localparam int NPROD      = 2 * MAX_DEGREE + 1;
  localparam int DEG_W      = $clog2(NDEG);
  localparam int PDEG_W     = $clog2(NPROD);
  localparam int PAIR_W     = 2 * DEG_W;
  localparam int COEF_W     = 32;
  localparam int OP_W       = 2;
  localparam int TDEG_W     = 4;
  localparam int ODEG_W     = 5;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_SUM    = 2'd2,
    OP_PROD   = 2'd3
  } op_t;

  typedef struct packed {
    logic              re;
    logic [DEG_W-1:0]  raddr;
    logic              we;
    logic [DEG_W-1:0]  waddr;
    logic [COEF_W-1:0] wdata;
  } coef_port_t;

  typedef struct packed {
    logic              re;
    logic [PDEG_W-1:0] raddr;
    logic              we;
    logic [PDEG_W-1:0] waddr;
    logic [COEF_W-1:0] wdata;
  } acc_port_t;

endpackage

`default_nettype wire

// File: hw/rtl/spa_if.sv
// ----------------------------------------------------------------------------
// spa_in_if / spa_out_if
// Valid/ready channels for term requests and result terms.
// ----------------------------------------------------------------------------
`default_nettype none

interface spa_in_if;
  logic                              valid;
  logic                              ready;
  logic [spa_pkg::OP_W-1:0]          op;
  logic signed [spa_pkg::COEF_W-1:0] term_coef;
  logic [spa_pkg::TDEG_W-1:0]        term_degree;

  modport source (output valid, op, term_coef, term_degree, input ready);
  modport sink   (input valid, op, term_coef, term_degree, output ready);
endinterface

interface spa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [spa_pkg::COEF_W-1:0] out_coef;
  logic [spa_pkg::ODEG_W-1:0]        out_degree;
  logic                              no_term;
  logic                              last;

  modport source (output valid, out_coef, out_degree, no_term, last, input ready);
  modport sink   (input valid, out_coef, out_degree, no_term, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spa_ram.sv
// ----------------------------------------------------------------------------
// spa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_ram #(
  parameter int DEPTH = 16,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/spa_seq.sv
// ----------------------------------------------------------------------------
// spa_seq
// Request sequencer: term loads, product multiply-accumulate pipeline and
// descending-degree result scan with a one-term lookahead for last.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  spa_in_if.sink                      in_ch,
  spa_out_if.source                   out_ch,
  output spa_pkg::coef_port_t         a_port,
  output spa_pkg::coef_port_t         b_port,
  output spa_pkg::acc_port_t          acc_port,
  input  logic [spa_pkg::COEF_W-1:0]  a_rdata,
  input  logic [spa_pkg::COEF_W-1:0]  b_rdata,
  input  logic [spa_pkg::COEF_W-1:0]  acc_rdata
);
  import spa_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LD_WR = 7'b0000010,
    ST_MAC   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_RD    = 7'b0010000,
    ST_EV    = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic                mode_prod_r, mode_prod_nxt;
  logic                ld_b_r, ld_b_nxt;
  logic [DEG_W-1:0]    ld_deg_r, ld_deg_nxt;
  logic [COEF_W-1:0]   ld_coef_r, ld_coef_nxt;
  logic [PAIR_W-1:0]   pc_r, pc_nxt;
  logic [PDEG_W-1:0]   d_r, d_nxt;
  logic [NDEG-1:0]     fp_r, fp_nxt;
  logic [NDEG-1:0]     sp_r, sp_nxt;
  logic [NPROD-1:0]    hit_r, hit_nxt;
  logic                v1_r, v1_nxt;
  logic [PDEG_W-1:0]   a1_r, a1_nxt;
  logic                v2_r, v2_nxt;
  logic [PDEG_W-1:0]   a2_r, a2_nxt;
  logic [COEF_W-1:0]   mul_r, mul_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [COEF_W-1:0]   pend_coef_r, pend_coef_nxt;
  logic [PDEG_W-1:0]   pend_deg_r, pend_deg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COEF_W-1:0]   out_coef_r, out_coef_nxt;
  logic [PDEG_W-1:0]   out_deg_r, out_deg_nxt;
  logic                out_none_r, out_none_nxt;
  logic                out_last_r, out_last_nxt;

  logic                out_free;
  logic                ld_ok;
  logic [DEG_W-1:0]    pi;
  logic [DEG_W-1:0]    pj;
  logic [DEG_W-1:0]    ds;
  logic                pa;
  logic                pb;
  logic [COEF_W-1:0]   ssum;
  logic                cand;
  logic [COEF_W-1:0]   cand_coef;

  assign pi       = pc_r[PAIR_W-1:DEG_W];
  assign pj       = pc_r[DEG_W-1:0];
  assign ds       = d_r[DEG_W-1:0];
  assign out_free = !out_valid_r || out_ch.ready;
  assign ld_ok    = (ODEG_W'(in_ch.term_degree) <= ODEG_W'(MAX_DEGREE));
  assign pa       = fp_r[ds];
  assign pb       = sp_r[ds];
  assign ssum     = a_rdata + b_rdata;

  always_comb begin
    if (mode_prod_r) begin
      cand      = hit_r[d_r];
      cand_coef = acc_rdata;
    end else if (pa && pb) begin
      cand      = (ssum != '0);
      cand_coef = ssum;
    end else begin
      cand      = pa || pb;
      cand_coef = pa ? a_rdata : b_rdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_prod_nxt = mode_prod_r;
    ld_b_nxt      = ld_b_r;
    ld_deg_nxt    = ld_deg_r;
    ld_coef_nxt   = ld_coef_r;
    pc_nxt        = pc_r;
    d_nxt         = d_r;
    fp_nxt        = fp_r;
    sp_nxt        = sp_r;
    hit_nxt       = hit_r;
    pend_v_nxt    = pend_v_r;
    pend_coef_nxt = pend_coef_r;
    pend_deg_nxt  = pend_deg_r;
    out_valid_nxt = out_valid_r;
    out_coef_nxt  = out_coef_r;
    out_deg_nxt   = out_deg_r;
    out_none_nxt  = out_none_r;
    out_last_nxt  = out_last_r;
    a_port        = '0;
    b_port        = '0;
    acc_port      = '0;
    in_ch.ready   = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // multiply-accumulate pipeline
    v1_nxt  = 1'b0;
    a1_nxt  = a1_r;
    v2_nxt  = v1_r;
    a2_nxt  = a1_r;
    mul_nxt = a_rdata * b_rdata;
    acc_port.re    = (state_r == ST_MAC) || (state_r == ST_DRAIN) || (state_r == ST_RD);
    acc_port.raddr = (state_r == ST_RD) ? d_r : a1_r;
    if (v2_r) begin
      acc_port.we    = 1'b1;
      acc_port.waddr = a2_r;
      acc_port.wdata = (hit_r[a2_r] ? acc_rdata : '0) + mul_r;
      hit_nxt[a2_r]  = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (op_t'(in_ch.op))
            OP_LOAD_A, OP_LOAD_B: begin
              ld_b_nxt    = (op_t'(in_ch.op) == OP_LOAD_B);
              ld_deg_nxt  = in_ch.term_degree[DEG_W-1:0];
              ld_coef_nxt = in_ch.term_coef;
              if (ld_ok) begin
                a_port.re    = (op_t'(in_ch.op) == OP_LOAD_A);
                a_port.raddr = in_ch.term_degree[DEG_W-1:0];
                b_port.re    = (op_t'(in_ch.op) == OP_LOAD_B);
                b_port.raddr = in_ch.term_degree[DEG_W-1:0];
                state_nxt    = ST_LD_WR;
              end
            end
            OP_SUM: begin
              mode_prod_nxt = 1'b0;
              d_nxt         = PDEG_W'(MAX_DEGREE);
              state_nxt     = ST_RD;
            end
            OP_PROD: begin
              mode_prod_nxt = 1'b1;
              hit_nxt       = '0;
              pc_nxt        = '0;
              state_nxt     = ST_MAC;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LD_WR: begin
        if (ld_b_r) begin
          b_port.we     = 1'b1;
          b_port.waddr  = ld_deg_r;
          b_port.wdata  = sp_r[ld_deg_r] ? b_rdata + ld_coef_r : ld_coef_r;
          sp_nxt[ld_deg_r] = 1'b1;
        end else begin
          a_port.we     = 1'b1;
          a_port.waddr  = ld_deg_r;
          a_port.wdata  = fp_r[ld_deg_r] ? a_rdata + ld_coef_r : ld_coef_r;
          fp_nxt[ld_deg_r] = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_MAC: begin
        a_port.re    = 1'b1;
        a_port.raddr = pi;
        b_port.re    = 1'b1;
        b_port.raddr = pj;
        v1_nxt       = fp_r[pi] && sp_r[pj];
        a1_nxt       = PDEG_W'(pi) + PDEG_W'(pj);
        pc_nxt       = pc_r + 1'b1;
        if (pc_r == PAIR_W'(NDEG * NDEG - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          d_nxt     = PDEG_W'(NPROD - 1);
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        a_port.re    = 1'b1;
        a_port.raddr = ds;
        b_port.re    = 1'b1;
        b_port.raddr = ds;
        state_nxt    = ST_EV;
      end
      ST_EV: begin
        if (!cand || !pend_v_r || out_free) begin
          if (cand) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_coef_nxt  = pend_coef_r;
              out_deg_nxt   = pend_deg_r;
              out_none_nxt  = 1'b0;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_coef_nxt = cand_coef;
            pend_deg_nxt  = d_r;
          end
          if (d_r == '0) begin
            state_nxt = ST_FIN;
          end else begin
            d_nxt     = d_r - 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_coef_nxt  = pend_v_r ? pend_coef_r : '0;
          out_deg_nxt   = pend_v_r ? pend_deg_r : '0;
          out_none_nxt  = !pend_v_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          if (!mode_prod_r) begin
            fp_nxt = '0;
            sp_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fp_r        <= '0;
      sp_r        <= '0;
      hit_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      sp_r        <= sp_nxt;
      hit_r       <= hit_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_prod_r <= mode_prod_nxt;
    ld_b_r      <= ld_b_nxt;
    ld_deg_r    <= ld_deg_nxt;
    ld_coef_r   <= ld_coef_nxt;
    pc_r        <= pc_nxt;
    d_r         <= d_nxt;
    a1_r        <= a1_nxt;
    a2_r        <= a2_nxt;
    mul_r       <= mul_nxt;
    pend_coef_r <= pend_coef_nxt;
    pend_deg_r  <= pend_deg_nxt;
    out_coef_r  <= out_coef_nxt;
    out_deg_r   <= out_deg_nxt;
    out_none_r  <= out_none_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_coef   = out_coef_r;
  assign out_ch.out_degree = ODEG_W'(out_deg_r);
  assign out_ch.no_term    = out_none_r;
  assign out_ch.last       = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/sparse_polynomial_add_multiply_top.sv
// load request: coefficient read, then write back; no result
// sum request: read-then-evaluate scan of the two coefficient RAMs,
// one degree at a time from degree 15 down to 0
// product request: one shared 32x32 multiplier over all 256 term pairs,
// a drain of the MAC pipeline, then a scan of the accumulator RAM
// reset clears the presence and hit marks at once; RAM contents need no clear
// ----------------------------------------------------------------------------
// sparse_polynomial_add_multiply_top
// Sparse polynomial adder and multiplier over per-degree coefficient RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_add_multiply_top (
  input  logic      clk,
  input  logic      rst_n,
  spa_in_if.sink    in_ch,
  spa_out_if.source out_ch
);
  import spa_pkg::*;

  coef_port_t        a_port;
  coef_port_t        b_port;
  acc_port_t         acc_port;
  logic [COEF_W-1:0] a_rdata;
  logic [COEF_W-1:0] b_rdata;
  logic [COEF_W-1:0] acc_rdata;

  spa_ram #(.DEPTH(NDEG), .DW(COEF_W)) u_first_ram (
    .clk   (clk),
    .we    (a_port.we),
    .waddr (a_port.waddr),
    .wdata (a_port.wdata),
    .re    (a_port.re),
    .raddr (a_port.raddr),
    .rdata (a_rdata)
  );

  spa_ram #(.DEPTH(NDEG), .DW(COEF_W)) u_second_ram (
    .clk   (clk),
    .we    (b_port.we),
    .waddr (b_port.waddr),
    .wdata (b_port.wdata),
    .re    (b_port.re),
    .raddr (b_port.raddr),
    .rdata (b_rdata)
  );

  spa_ram #(.DEPTH(NPROD), .DW(COEF_W)) u_acc_ram (
    .clk   (clk),
    .we    (acc_port.we),
    .waddr (acc_port.waddr),
    .wdata (acc_port.wdata),
    .re    (acc_port.re),
    .raddr (acc_port.raddr),
    .rdata (acc_rdata)
  );

  spa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .a_port    (a_port),
    .b_port    (b_port),
    .acc_port  (acc_port),
    .a_rdata   (a_rdata),
    .b_rdata   (b_rdata),
    .acc_rdata (acc_rdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/spa_chk.sv
// ----------------------------------------------------------------------------
// spa_chk
// Port-level checks of the sparse polynomial block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [spa_pkg::COEF_W-1:0]    out_coef,
  input logic [spa_pkg::ODEG_W-1:0]    out_degree,
  input logic                          out_no_term,
  input logic                          out_last
);
  import spa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coef) &&
    $stable(out_degree) && $stable(out_no_term) && $stable(out_last))
    else $error("result changed while stalled");

  // empty result is a single zero item
  a_no_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_term |-> out_last && out_coef == '0 && out_degree == '0)
    else $error("bad empty-result item");

  // no request is taken in the cycle after another
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");

  // result degree stays within the product range
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_degree <= ODEG_W'(NPROD - 1))
    else $error("result degree out of range");

endmodule

bind sparse_polynomial_add_multiply_top spa_chk u_spa_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_coef    (out_ch.out_coef),
  .out_degree  (out_ch.out_degree),
  .out_no_term (out_ch.no_term),
  .out_last    (out_ch.last)
);

`default_nettype wire
